[rtl/core/mcog_pkg.sv]
`timescale 1ns / 1ps
package mcog_pkg;

   localparam int FIELD_W     = 7;
   localparam int MAX_RESULTS = 46;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH
   } seq_state_type;

endpackage

[rtl/core/mcog_req_if.sv]
`timescale 1ns / 1ps
interface mcog_req_if;
   import mcog_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] radius;

   modport source (output valid, output radius, input ready);
   modport sink (input valid, input radius, output ready);
endinterface

[rtl/core/mcog_rsp_if.sv]
`timescale 1ns / 1ps
interface mcog_rsp_if;
   import mcog_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] px;
   logic [FIELD_W-1:0] py;
   logic               last;
   logic               no_point;

   modport source (output valid, output px, output py, output last, output no_point,
                   input ready);
   modport sink (input valid, input px, input py, input last, input no_point,
                 output ready);
endinterface

[rtl/core/mcog_step.sv]
`timescale 1ns / 1ps
module mcog_step #(
   parameter int CW = 8,
   parameter int DW = 11
) (
   input  logic signed [CW-1:0] x,
   input  logic signed [CW-1:0] y,
   input  logic signed [DW-1:0] d,
   input  logic                 first,
   output logic signed [CW-1:0] nx,
   output logic signed [CW-1:0] ny,
   output logic signed [DW-1:0] nd,
   output logic                 emit
);
   import mcog_pkg::*;

   logic signed [DW-1:0] xe;
   logic signed [DW-1:0] ye;
   logic signed [DW-1:0] diff;
   logic signed [DW-1:0] inc;

   always_comb begin
      xe   = DW'(x);
      ye   = DW'(y);
      diff = xe - ye;
      // decision is tested before the update picks its increment
      if (d[DW-1]) begin
         inc = (xe <<< 1) + DW'(2);
      end else begin
         inc = (diff <<< 1) + DW'(2);
      end
      nd   = first ? d : d + inc;
      nx   = x + CW'(1);
      ny   = nd[DW-1] ? y : y - CW'(1);
      emit = (ny >= nx);
   end

endmodule

[rtl/core/midpoint_circle_octant_generator.sv]
`timescale 1ns / 1ps
// The first result is registered when the next point is found, or in the flush
// state when the radius has a single point. Throughput: one point per cycle, one
// step of the single decision unit, while the output is taken; a radius holds the
// block until its last point is registered. req_bus.ready is high only while idle.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module midpoint_circle_octant_generator #(
   parameter int MAX_RADIUS = 64
) (
   input  logic        clock,
   input  logic        reset,
   mcog_req_if.sink    req_bus,
   mcog_rsp_if.source  rsp_bus
);
   import mcog_pkg::*;

   localparam int RMAX = (MAX_RADIUS < 127) ? MAX_RADIUS : 127;
   localparam int CW   = $clog2(RMAX + 2) + 1;
   localparam int DW   = CW + 3;

   seq_state_type        state_ff, state_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic                 first_ff, first_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_v_ff, pend_v_in;
   logic signed [CW-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;

   logic                 rsp_v_ff, rsp_v_in;
   logic [FIELD_W-1:0]   rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic                 rsp_last_ff, rsp_last_in, rsp_none_ff, rsp_none_in;

   logic signed [CW-1:0] rad_c;
   logic signed [CW-1:0] nx, ny;
   logic signed [DW-1:0] nd;
   logic                 emit;
   logic                 out_free;
   logic                 push;
   logic [FIELD_W-1:0]   push_x, push_y;
   logic                 push_last, push_none;

   mcog_step #(.CW(CW), .DW(DW)) u_step (
      .x     (x_ff),
      .y     (y_ff),
      .d     (d_ff),
      .first (first_ff),
      .nx    (nx),
      .ny    (ny),
      .nd    (nd),
      .emit  (emit)
   );

   assign rad_c    = (int'(req_bus.radius) > RMAX) ? CW'(RMAX) : CW'(req_bus.radius);
   assign out_free = !rsp_v_ff || rsp_bus.ready;

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      pend_v_in = pend_v_ff;
      pend_x_in = pend_x_ff;
      pend_y_in = pend_y_ff;
      push      = 1'b0;
      push_x    = FIELD_W'(pend_x_ff);
      push_y    = FIELD_W'(pend_y_ff);
      push_last = 1'b0;
      push_none = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               x_in      = '0;
               y_in      = rad_c;
               d_in      = DW'(1) - DW'(rad_c);
               first_in  = 1'b1;
               cnt_in    = '0;
               pend_v_in = 1'b0;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (out_free) begin
               x_in     = nx;
               y_in     = ny;
               d_in     = nd;
               first_in = 1'b0;
               if (emit) begin
                  // previous point is known not to be last now
                  push      = pend_v_ff;
                  pend_v_in = 1'b1;
                  pend_x_in = nx;
                  pend_y_in = ny;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  if (cnt_ff == CNT_W'(MAX_RESULTS - 1)) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               if (!pend_v_ff) begin
                  push_x    = '0;
                  push_y    = '0;
                  push_none = 1'b1;
               end
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_v_in    = rsp_v_ff;
      rsp_px_in   = rsp_px_ff;
      rsp_py_in   = rsp_py_ff;
      rsp_last_in = rsp_last_ff;
      rsp_none_in = rsp_none_ff;
      if (push) begin
         rsp_v_in    = 1'b1;
         rsp_px_in   = push_x;
         rsp_py_in   = push_y;
         rsp_last_in = push_last;
         rsp_none_in = push_none;
      end else if (rsp_bus.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      d_ff        <= d_in;
      first_ff    <= first_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_px_ff   <= rsp_px_in;
      rsp_py_ff   <= rsp_py_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = rsp_v_ff;
   assign rsp_bus.px       = rsp_px_ff;
   assign rsp_bus.py       = rsp_py_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign rsp_bus.no_point = rsp_none_ff;

`ifndef SYNTHESIS
   a_point_in_octant: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_none_ff |-> (rsp_px_ff <= rsp_py_ff) && (rsp_px_ff != '0))
      else $error("emitted point outside the octant");

   a_no_point_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_none_ff |-> rsp_last_ff && (rsp_px_ff == '0) && (rsp_py_ff == '0))
      else $error("empty result not flagged as last with zero point");

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> (state_ff == ST_STEP) && first_ff && !pend_v_ff)
      else $error("radius beat did not start a walk");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("point count beyond cap");
`endif

endmodule
